>>> hdl/vna_pkg.sv
// Shared constants and types for the vertex normal accumulation unit.
package vna_pkg;

    localparam int IDX_W        = 10;
    localparam int SUM_W        = 64;
    localparam int NRM_W        = 16;
    localparam int MAG_W        = 30;
    localparam int SQ_W         = 62;
    localparam int LEN_W        = 31;
    localparam int NUM_W        = 46;
    localparam int QUO_W        = 16;

    localparam int DEF_MAX_VERTICES  = 1024;
    localparam int DEF_MAX_TRIANGLES = 2048;
    localparam int DEF_COORD_BITS    = 18;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_VERT  = 2'd1;
    localparam logic [1:0] MODE_TRI   = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic [SUM_W-1:0] SCALE_LO = SUM_W'(1) << 29;
    localparam logic [SUM_W-1:0] SCALE_HI = SUM_W'(1) << 30;

    typedef struct packed {
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] a;
    } tri_t;

endpackage

>>> hdl/vertex_normal_accumulation_unit.sv
// Top level: mesh stores, triangle scan, cross-product accumulation and normalization.
//
// Usage: drive start with mode and the payload fields; a word is taken at a rising
// edge where start is high and busy is low.
// Mode 0 clears the vertex and triangle counts, mode 1 appends a vertex, mode 2
// appends a triangle; busy stays low for these. Loads past capacity are dropped.
// Mode 3 queries vertex corner_a: busy rises and the unit scans the triangle
// memory, reading and checking each stored triangle; for each triangle that names
// the vertex it does three vertex memory reads on one port and six products through
// one multiplier. Normalization then shifts the magnitudes into range, squares and
// sums them, takes the square root and divides each component by the root.
// The result is presented for exactly one cycle with done high, in the first
// cycle in which busy is low again; the receiver cannot stall it.
// Reset clears the counts and control state; memory contents are left as is.
module vertex_normal_accumulation_unit
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
    parameter int COORD_BITS    = DEF_COORD_BITS
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   mode,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic [IDX_W-1:0]             corner_a,
    input  logic [IDX_W-1:0]             corner_b,
    input  logic [IDX_W-1:0]             corner_c,
    output logic                         done,
    output logic [IDX_W-1:0]             vertex_index,
    output logic signed [NRM_W-1:0]      normal_x,
    output logic signed [NRM_W-1:0]      normal_y,
    output logic signed [NRM_W-1:0]      normal_z,
    output logic                         degenerate
);

    localparam int VA_W   = $clog2(MAX_VERTICES);
    localparam int TA_W   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int VC_W   = $clog2(MAX_VERTICES + 1);
    localparam int TC_W   = $clog2(MAX_TRIANGLES + 1);
    localparam int D_W    = COORD_BITS + 1;
    localparam int PROD_W = 2 * D_W;
    localparam int VW_W   = 3 * COORD_BITS;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_T_RD  = 5'd1;
    localparam logic [4:0] ST_T_CHK = 5'd2;
    localparam logic [4:0] ST_V_A   = 5'd3;
    localparam logic [4:0] ST_V_B   = 5'd4;
    localparam logic [4:0] ST_V_C   = 5'd5;
    localparam logic [4:0] ST_V_CAP = 5'd6;
    localparam logic [4:0] ST_DIFF  = 5'd7;
    localparam logic [4:0] ST_MUL   = 5'd8;
    localparam logic [4:0] ST_ZCHK  = 5'd9;
    localparam logic [4:0] ST_MAX   = 5'd10;
    localparam logic [4:0] ST_NORM  = 5'd11;
    localparam logic [4:0] ST_SQ    = 5'd12;
    localparam logic [4:0] ST_SQRT  = 5'd13;
    localparam logic [4:0] ST_DSET  = 5'd14;
    localparam logic [4:0] ST_DRUN  = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;

    logic [VW_W-1:0]  vert_mem [MAX_VERTICES];
    tri_t             tri_mem  [MAX_TRIANGLES];
    logic [VW_W-1:0]  vert_q;
    tri_t             tri_q;
    logic [VA_W-1:0]  vert_raddr;
    logic [IDX_W-1:0] vert_ridx;

    logic [4:0]       state_reg;
    logic [VC_W-1:0]  vcnt_reg;
    logic [TC_W-1:0]  tcnt_reg;
    logic [TC_W-1:0]  t_reg;
    logic [IDX_W-1:0] qv_reg;
    tri_t             hit_reg;
    logic             ok_reg;
    logic [VW_W-1:0]  va_reg, vb_reg;
    logic signed [D_W-1:0]    px_reg, py_reg, pz_reg, qx_reg, qy_reg, qz_reg;
    logic signed [D_W-1:0]    op1, op2;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2:0]       cnt_reg;
    logic [SUM_W-1:0] sum_reg [3];
    logic [SUM_W-1:0] mag_reg [3];
    logic [2:0]       neg_reg;
    logic [SUM_W-1:0] m_reg;
    logic [2*MAG_W-1:0] sq_reg;
    logic [SQ_W-1:0]  n_reg, res_reg, bit_reg;
    logic [SQ_W-1:0]  trial;
    logic [1:0]       k_reg;
    logic [4:0]       step_reg;
    logic [32:0]      rem_reg;
    logic [32:0]      rem_try;
    logic [15:0]      nlo_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [NUM_W-1:0] num;
    logic [31:0]      dvs;
    logic [NRM_W-1:0] nrm_reg [3];
    logic             done_reg, degen_reg;

    always_comb
    begin
        vert_ridx = hit_reg.a;
        unique case (state_reg)
            ST_V_B:  vert_ridx = hit_reg.b;
            ST_V_C:  vert_ridx = hit_reg.c;
            default: vert_ridx = hit_reg.a;
        endcase
        vert_raddr = VA_W'(vert_ridx);
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && mode == MODE_VERT && 32'(vcnt_reg) < MAX_VERTICES)
        begin
            vert_mem[VA_W'(vcnt_reg)] <= {pos_x, pos_y, pos_z};
        end
        vert_q <= vert_mem[vert_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && mode == MODE_TRI && 32'(tcnt_reg) < MAX_TRIANGLES)
        begin
            tri_mem[TA_W'(tcnt_reg)] <= '{c: corner_c, b: corner_b, a: corner_a};
        end
        tri_q <= tri_mem[TA_W'(t_reg)];
    end

    always_comb
    begin
        op1 = py_reg;
        op2 = qz_reg;
        case (cnt_reg)
            3'd1:    begin op1 = pz_reg; op2 = qy_reg; end
            3'd2:    begin op1 = pz_reg; op2 = qx_reg; end
            3'd3:    begin op1 = px_reg; op2 = qz_reg; end
            3'd4:    begin op1 = px_reg; op2 = qy_reg; end
            3'd5:    begin op1 = py_reg; op2 = qx_reg; end
            default: begin op1 = py_reg; op2 = qz_reg; end
        endcase
    end

    assign trial   = res_reg + bit_reg;
    assign num     = (NUM_W'(mag_reg[k_reg][MAG_W-1:0]) << 15) + NUM_W'(res_reg);
    assign dvs     = 32'(res_reg) << 1;
    assign rem_try = {rem_reg[31:0], nlo_reg[15]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vcnt_reg  <= '0;
            tcnt_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        unique case (mode)
                            MODE_CLEAR:
                            begin
                                vcnt_reg <= '0;
                                tcnt_reg <= '0;
                            end
                            MODE_VERT:
                            begin
                                if (32'(vcnt_reg) < MAX_VERTICES)
                                    vcnt_reg <= vcnt_reg + 1'b1;
                            end
                            MODE_TRI:
                            begin
                                if (32'(tcnt_reg) < MAX_TRIANGLES)
                                    tcnt_reg <= tcnt_reg + 1'b1;
                            end
                            MODE_QUERY:
                            begin
                                qv_reg     <= corner_a;
                                t_reg      <= '0;
                                sum_reg[0] <= '0;
                                sum_reg[1] <= '0;
                                sum_reg[2] <= '0;
                                state_reg  <= ST_T_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_T_RD:
                begin
                    state_reg <= (t_reg < tcnt_reg) ? ST_T_CHK : ST_ZCHK;
                end
                ST_T_CHK:
                begin
                    t_reg <= t_reg + 1'b1;
                    if (tri_q.a == qv_reg || tri_q.b == qv_reg || tri_q.c == qv_reg)
                    begin
                        hit_reg   <= tri_q;
                        state_reg <= ST_V_A;
                    end
                    else
                        state_reg <= ST_T_RD;
                end
                ST_V_A:
                begin
                    ok_reg    <= 32'(hit_reg.a) < MAX_VERTICES;
                    state_reg <= ST_V_B;
                end
                ST_V_B:
                begin
                    va_reg    <= ok_reg ? vert_q : '0;
                    ok_reg    <= 32'(hit_reg.b) < MAX_VERTICES;
                    state_reg <= ST_V_C;
                end
                ST_V_C:
                begin
                    vb_reg    <= ok_reg ? vert_q : '0;
                    ok_reg    <= 32'(hit_reg.c) < MAX_VERTICES;
                    state_reg <= ST_V_CAP;
                end
                ST_V_CAP:
                begin
                    px_reg <= D_W'(signed'(vert_q[VW_W-1 -: COORD_BITS]))
                            - D_W'(signed'(va_reg[VW_W-1 -: COORD_BITS]));
                    py_reg <= D_W'(signed'(vert_q[2*COORD_BITS-1 -: COORD_BITS]))
                            - D_W'(signed'(va_reg[2*COORD_BITS-1 -: COORD_BITS]));
                    pz_reg <= D_W'(signed'(vert_q[COORD_BITS-1:0]))
                            - D_W'(signed'(va_reg[COORD_BITS-1:0]));
                    qx_reg <= D_W'(signed'(vb_reg[VW_W-1 -: COORD_BITS]))
                            - D_W'(signed'(va_reg[VW_W-1 -: COORD_BITS]));
                    qy_reg <= D_W'(signed'(vb_reg[2*COORD_BITS-1 -: COORD_BITS]))
                            - D_W'(signed'(va_reg[2*COORD_BITS-1 -: COORD_BITS]));
                    qz_reg <= D_W'(signed'(vb_reg[COORD_BITS-1:0]))
                            - D_W'(signed'(va_reg[COORD_BITS-1:0]));
                    if (!ok_reg)
                    begin
                        px_reg <= -D_W'(signed'(va_reg[VW_W-1 -: COORD_BITS]));
                        py_reg <= -D_W'(signed'(va_reg[2*COORD_BITS-1 -: COORD_BITS]));
                        pz_reg <= -D_W'(signed'(va_reg[COORD_BITS-1:0]));
                    end
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg <= op1 * op2;
                    if (cnt_reg != 3'd0)
                    begin
                        if (cnt_reg[0])
                            sum_reg[2'((cnt_reg - 3'd1) >> 1)]
                                <= sum_reg[2'((cnt_reg - 3'd1) >> 1)] + SUM_W'(prod_reg);
                        else
                            sum_reg[2'((cnt_reg - 3'd1) >> 1)]
                                <= sum_reg[2'((cnt_reg - 3'd1) >> 1)] - SUM_W'(prod_reg);
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd6)
                        state_reg <= ST_T_RD;
                end
                ST_ZCHK:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= sum_reg[i][SUM_W-1];
                        mag_reg[i] <= sum_reg[i][SUM_W-1] ? -sum_reg[i] : sum_reg[i];
                    end
                    if (sum_reg[0] == '0 && sum_reg[1] == '0 && sum_reg[2] == '0)
                    begin
                        nrm_reg[0] <= '0;
                        nrm_reg[1] <= '0;
                        nrm_reg[2] <= '0;
                        degen_reg  <= 1'b1;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        degen_reg <= 1'b0;
                        state_reg <= ST_MAX;
                    end
                end
                ST_MAX:
                begin
                    if (mag_reg[0] >= mag_reg[1] && mag_reg[0] >= mag_reg[2])
                        m_reg <= mag_reg[0];
                    else if (mag_reg[1] >= mag_reg[2])
                        m_reg <= mag_reg[1];
                    else
                        m_reg <= mag_reg[2];
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    if (m_reg >= SCALE_HI)
                    begin
                        for (int i = 0; i < 3; i++)
                            mag_reg[i] <= mag_reg[i] >> 1;
                        m_reg <= m_reg >> 1;
                    end
                    else if (m_reg < SCALE_LO)
                    begin
                        for (int i = 0; i < 3; i++)
                            mag_reg[i] <= mag_reg[i] << 1;
                        m_reg <= m_reg << 1;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        n_reg     <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (cnt_reg != 3'd3)
                        sq_reg <= mag_reg[cnt_reg[1:0]][MAG_W-1:0]
                                * mag_reg[cnt_reg[1:0]][MAG_W-1:0];
                    if (cnt_reg != 3'd0)
                        n_reg <= n_reg + SQ_W'(sq_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd3)
                    begin
                        res_reg   <= '0;
                        bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (n_reg >= trial)
                    begin
                        n_reg   <= n_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == SQ_W'(1))
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_DSET;
                    end
                end
                ST_DSET:
                begin
                    rem_reg   <= 33'(num[NUM_W-1:16]);
                    nlo_reg   <= num[15:0];
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DRUN;
                end
                ST_DRUN:
                begin
                    if (rem_try >= 33'(dvs))
                    begin
                        rem_reg <= rem_try - 33'(dvs);
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_try;
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    nlo_reg  <= nlo_reg << 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd16)
                    begin
                        nrm_reg[k_reg] <= neg_reg[k_reg] ? -NRM_W'(quo_reg)
                                                        : NRM_W'(quo_reg);
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg == 2'd2) ? ST_OUT : ST_DSET;
                    end
                end
                ST_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign vertex_index = qv_reg;
    assign normal_x     = nrm_reg[0];
    assign normal_y     = nrm_reg[1];
    assign normal_z     = nrm_reg[2];
    assign degenerate   = degen_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result without a finished query");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate result carries a nonzero normal");

    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
        else $error("normal lost its length");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        32'(vcnt_reg) <= MAX_VERTICES && 32'(tcnt_reg) <= MAX_TRIANGLES)
        else $error("store count past capacity");

endmodule
